FILE: src/tbt_pkg.sv
// Shared types and constants for the trickle beacon timer.
package tbt_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int DIV_BITS      = 32;
    localparam int CNT_W         = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int IN_DATA_W     = 64;
    localparam int OUT_DATA_W    = 40;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

    localparam logic [31:0]      MIN_INTERVAL_RST = 32'd100;
    localparam logic [31:0]      MAX_INTERVAL_RST = 32'd60000;
    localparam logic [CNT_W-1:0] REDUNDANCY_RST   = 8'd2;
    localparam logic             SUPPRESS_RST     = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REDUNDANCY_K = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPRESS_EN  = 2'd3;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_HEARD = 2'd1;
    localparam logic [1:0] MODE_RESET = 2'd2;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DIV_BITS-1:0] rem;
    } tbt_div_stat_t;

endpackage

FILE: src/trickle_beacon_timer_unit.sv
// Trickle beacon timer: per-transaction control and state, serial fire offset.
// Steps: heard, ignored and idle ticks pass evaluate, check and emit; when a new
//   fire point is drawn, a 32-step serial modulo and a plan step come before emit.
// Flow: one transaction at a time; the next is taken once the result sits in
//   the output register.
// Reset: rst_n clears timer state and restores register defaults at once.
module trickle_beacon_timer_unit
#(
    parameter int TIME_BITS = tbt_pkg::TIME_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [tbt_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // now_ms[31:0], rand_word[63:32]
    input  logic [1:0]                       s_axis_tuser,  // mode[1:0]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [tbt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // send_beacon[0], interval_now[32:1], zero pad
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tbt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tbt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_CHK  = 6'b000100,
        S_DIV  = 6'b001000,
        S_PLAN = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0]      min_int_reg;
    logic [31:0]      max_int_reg;
    logic [CNT_W-1:0] red_k_reg;
    logic             sup_en_reg;

    logic                 started_reg, started_next;
    logic                 sched_reg, sched_next;
    logic [31:0]          len_reg, len_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [TIME_BITS-1:0] fire_reg, fire_next;
    logic [CNT_W-1:0]     heard_reg, heard_next;
    logic                 send_reg, send_next;

    logic [1:0]  mode_reg;
    logic [31:0] now_reg;
    logic [31:0] rnd_reg;

    logic        out_valid_reg, out_valid_next;
    logic        out_send_reg;
    logic [31:0] out_len_reg;
    logic        out_load;

    logic [63:0]          now_wide;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] fire_diff;
    logic [TIME_BITS-1:0] elapsed;
    logic                 elapsed_ge;
    logic [32:0]          dbl;
    logic [31:0]          dbl_sat;
    logic [31:0]          dbl_cap;
    logic [31:0]          half;
    logic [31:0]          offset;
    logic [63:0]          fire_sum;
    logic                 in_take;

    logic          div_start;
    logic [31:0]   div_divisor;
    tbt_div_stat_t div_stat;

    tbt_serial_mod u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rnd_reg),
        .divisor  (div_divisor),
        .stat     (div_stat)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign now_wide   = {32'd0, now_reg};
    assign now_t      = now_wide[TIME_BITS-1:0];
    assign fire_diff  = now_t - fire_reg;
    assign elapsed    = now_t - start_reg;
    assign elapsed_ge = 64'(elapsed) >= 64'(len_reg);
    assign dbl        = {len_reg, 1'b0};
    assign dbl_sat    = dbl[32] ? 32'hFFFF_FFFF : dbl[31:0];
    assign dbl_cap    = (dbl_sat > max_int_reg) ? max_int_reg : dbl_sat;
    assign half       = {1'b0, len_reg[31:1]};
    assign offset     = (half == 32'd0) ? 32'd0 : div_stat.rem;
    assign fire_sum   = 64'(now_t) + 64'(half) + 64'(offset);
    assign out_load   = (state_reg == S_EMIT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next   = state_reg;
        started_next = started_reg;
        sched_next   = sched_reg;
        len_next     = len_reg;
        start_next   = start_reg;
        fire_next    = fire_reg;
        heard_next   = heard_reg;
        send_next    = send_reg;
        div_start    = 1'b0;
        div_divisor  = {1'b0, min_int_reg[31:1]};
        unique case (state_reg)
            S_IDLE:
            begin
                send_next = 1'b0;
                if (in_take)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (mode_reg == MODE_HEARD)
                begin
                    if (heard_reg < COUNT_MAX)
                        heard_next = heard_reg + 1'b1;
                end
                else if (mode_reg == MODE_TICK && started_reg && sched_reg
                         && !fire_diff[TIME_BITS-1])
                begin
                    send_next  = !sup_en_reg || (heard_reg < red_k_reg);
                    sched_next = 1'b0;
                end
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = S_EMIT;
                if (mode_reg == MODE_RESET)
                begin
                    started_next = 1'b1;
                    len_next     = min_int_reg;
                    div_divisor  = {1'b0, min_int_reg[31:1]};
                    div_start    = 1'b1;
                    state_next   = S_DIV;
                end
                else if (mode_reg == MODE_TICK && started_reg && !sched_reg && elapsed_ge)
                begin
                    len_next    = dbl_cap;
                    div_divisor = {1'b0, dbl_cap[31:1]};
                    div_start   = 1'b1;
                    state_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = S_PLAN;
            end
            S_PLAN:
            begin
                start_next = now_t;
                heard_next = '0;
                fire_next  = fire_sum[TIME_BITS-1:0];
                sched_next = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tvalid && m_axis_tready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            sched_reg     <= 1'b0;
            len_reg       <= '0;
            start_reg     <= '0;
            fire_reg      <= '0;
            heard_reg     <= '0;
            send_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            min_int_reg   <= MIN_INTERVAL_RST;
            max_int_reg   <= MAX_INTERVAL_RST;
            red_k_reg     <= REDUNDANCY_RST;
            sup_en_reg    <= SUPPRESS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            sched_reg     <= sched_next;
            len_reg       <= len_next;
            start_reg     <= start_next;
            fire_reg      <= fire_next;
            heard_reg     <= heard_next;
            send_reg      <= send_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_MIN_INTERVAL: min_int_reg <= cfg_data;
                    REG_MAX_INTERVAL: max_int_reg <= cfg_data;
                    REG_REDUNDANCY_K: red_k_reg   <= cfg_data[CNT_W-1:0];
                    REG_SUPPRESS_EN:  sup_en_reg  <= cfg_data[0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg <= s_axis_tuser;
            now_reg  <= s_axis_tdata[31:0];
            rnd_reg  <= s_axis_tdata[63:32];
        end
        if (out_load)
        begin
            out_send_reg <= send_reg;
            out_len_reg  <= len_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_len_reg, out_send_reg};

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV)
        else $error("remainder finished outside the wait state");

    a_plan_arms: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PLAN |=> sched_reg && started_reg)
        else $error("fire point planned but not armed");

    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_EMIT))
        else $error("result appeared without an emit step");

    a_send_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        send_reg && state_reg == S_CHK |-> mode_reg == MODE_TICK && started_reg)
        else $error("beacon requested on a non-tick transaction");

endmodule

FILE: src/tbt_serial_mod.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module tbt_serial_mod
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tbt_pkg::DIV_BITS-1:0]  dividend,
    input  logic [tbt_pkg::DIV_BITS-1:0]  divisor,
    output tbt_pkg::tbt_div_stat_t        stat
);
    import tbt_pkg::*;

    localparam int CW = $clog2(DIV_BITS);

    logic [DIV_BITS-1:0] rem_reg, rem_next;
    logic [DIV_BITS-1:0] dvd_reg, dvd_next;
    logic [DIV_BITS-1:0] dsr_reg, dsr_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [DIV_BITS:0]   trial;
    logic [DIV_BITS:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DIV_BITS-1]};
        diff      = trial - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // keep the trial difference when the divisor fits
            rem_next = diff[DIV_BITS] ? trial[DIV_BITS-1:0] : diff[DIV_BITS-1:0];
            dvd_next = {dvd_reg[DIV_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule

FILE: bench/trickle_beacon_timer_unit_test.sv
// Self-checking bench for the trickle beacon timer: streamed events, scoreboard, reg writes.
module trickle_beacon_timer_unit_test;
    import tbt_pkg::*;

    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam int         DRAIN_CYCLES = 50;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] now_ms;
        logic [31:0] rand_word;
    } beacon_evt_t;

    typedef struct packed {
        logic        send_beacon;
        logic [31:0] interval_now;
    } timer_out_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata = '0;   // now_ms[31:0], rand_word[63:32]
    logic [1:0]              s_axis_tuser = '0;   // mode[1:0]
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;        // send_beacon[0], interval_now[32:1]
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    trickle_beacon_timer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    beacon_evt_t evt_pending[$];
    timer_out_t  timer_results_due[$];

    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    bit  hold_inputs = 1'b0;
    bit  in_taken = 1'b0;
    int  err_count = 0;
    int  events_taken = 0;
    int  results_seen = 0;
    int  beacons_due = 0;
    logic [31:0] clock_ms = 32'd0;

    // timer model: register copies and state
    logic [31:0] cfg_min = MIN_INTERVAL_RST;
    logic [31:0] cfg_max = MAX_INTERVAL_RST;
    logic [7:0]  cfg_k = REDUNDANCY_RST;
    logic        cfg_suppress = SUPPRESS_RST;
    bit          t_started = 1'b0;
    bit          t_sched = 1'b0;
    logic [31:0] t_len = '0;
    logic [31:0] t_start = '0;
    logic [31:0] t_fire = '0;
    logic [7:0]  t_heard = '0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        err_count++;
    endtask

    // new interval starts now; fire point lands in the second half
    function automatic void arm_fire(input logic [31:0] now, input logic [31:0] rnd);
        logic [31:0] half;
        logic [31:0] off;
        half = t_len >> 1;
        off = (half != 0) ? (rnd % half) : 32'd0;
        t_start = now;
        t_heard = '0;
        t_fire = now + half + off;
        t_sched = 1'b1;
    endfunction

    function automatic timer_out_t trickle_predict(input beacon_evt_t ev);
        timer_out_t  r;
        logic [31:0] since_fire;
        logic [32:0] dbl;
        r.send_beacon = 1'b0;
        case (ev.mode)
            MODE_RESET:
            begin
                t_len = cfg_min;
                t_started = 1'b1;
                arm_fire(ev.now_ms, ev.rand_word);
            end
            MODE_HEARD:
            begin
                if (t_heard != COUNT_MAX)
                    t_heard = t_heard + 8'd1;
            end
            MODE_TICK:
            begin
                if (t_started)
                begin
                    since_fire = ev.now_ms - t_fire;
                    if (t_sched && !since_fire[31])
                    begin
                        r.send_beacon = !cfg_suppress || (t_heard < cfg_k);
                        t_sched = 1'b0;
                    end
                    if (!t_sched && (ev.now_ms - t_start) >= t_len)
                    begin
                        dbl = {t_len, 1'b0};
                        if (dbl[32])
                            dbl = {1'b0, 32'hFFFF_FFFF};
                        if (dbl[31:0] > cfg_max)
                            dbl = {1'b0, cfg_max};
                        t_len = dbl[31:0];
                        arm_fire(ev.now_ms, ev.rand_word);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.interval_now = t_len;
        return r;
    endfunction

    // input side: prediction happens when the transaction is taken
    always @(posedge clk)
    begin : accept_inputs
        beacon_evt_t ev;
        timer_out_t  want;
        in_taken = s_axis_tvalid && s_axis_tready;
        if (in_taken)
        begin
            ev.mode = s_axis_tuser;
            ev.now_ms = s_axis_tdata[31:0];
            ev.rand_word = s_axis_tdata[63:32];
            want = trickle_predict(ev);
            timer_results_due.push_back(want);
            events_taken++;
            if (want.send_beacon)
                beacons_due++;
        end
    end

    always @(negedge clk)
    begin : drive_inputs
        beacon_evt_t ev;
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_taken)
            begin
                if (evt_pending.size() != 0 && !hold_inputs &&
                    $urandom_range(99) >= src_idle_pct)
                begin
                    ev = evt_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {ev.rand_word, ev.now_ms};
                    s_axis_tuser <= ev.mode;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        timer_out_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (timer_results_due.size() == 0)
            begin
                flag_mismatch("result with nothing pending", m_axis_tdata[32:1], 32'd0);
            end
            else
            begin
                want = timer_results_due.pop_front();
                if (m_axis_tdata[0] !== want.send_beacon)
                    flag_mismatch("send_beacon", {31'd0, m_axis_tdata[0]},
                                  {31'd0, want.send_beacon});
                if (m_axis_tdata[32:1] !== want.interval_now)
                    flag_mismatch("interval_now", m_axis_tdata[32:1], want.interval_now);
                if (m_axis_tdata[OUT_DATA_W-1:33] !== '0)
                    flag_mismatch("pad bits", {25'd0, m_axis_tdata[OUT_DATA_W-1:33]}, 32'd0);
            end
        end
    end

    task automatic push_evt(input logic [1:0] mode, input logic [31:0] now,
                            input logic [31:0] rnd);
        beacon_evt_t ev;
        ev.mode = mode;
        ev.now_ms = now;
        ev.rand_word = rnd;
        evt_pending.push_back(ev);
    endtask

    // keep_pending: only wait for the in-flight transaction and its result
    task automatic wait_drained(input bit keep_pending);
        while ((!keep_pending && evt_pending.size() != 0) || s_axis_tvalid ||
               timer_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_MIN_INTERVAL: cfg_min = value;
            REG_MAX_INTERVAL: cfg_max = value;
            REG_REDUNDANCY_K: cfg_k = value[7:0];
            REG_SUPPRESS_EN:  cfg_suppress = value[0];
            default: ;
        endcase
    endtask

    task automatic set_timer_regs(input logic [31:0] min_ms, input logic [31:0] max_ms,
                                  input logic [7:0] k, input logic sup);
        wait_drained(1'b0);
        write_reg(REG_MIN_INTERVAL, min_ms);
        write_reg(REG_MAX_INTERVAL, max_ms);
        write_reg(REG_REDUNDANCY_K, {24'd0, k});
        write_reg(REG_SUPPRESS_EN, {31'd0, sup});
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // starts with a reset, then mostly ticks on a moving clock with heard beacons
    // mixed in; occasional wild jumps move time backward or far ahead
    task automatic make_traffic(input int n, input logic [31:0] step_cap,
                                input bit heard_flood);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if ($urandom_range(99) < 6)
                clock_ms = clock_ms + $urandom;
            else
                clock_ms = clock_ms + $urandom_range(0, step_cap);
            if (i == 0 || pick < 5)
                push_evt(MODE_RESET, clock_ms, $urandom);
            else if (pick < 25)
                push_evt(MODE_HEARD, clock_ms, $urandom);
            else if (pick < 28)
                push_evt(MODE_IGNORED, clock_ms, $urandom);
            else
                push_evt(MODE_TICK, clock_ms, $urandom);
            // drive the heard counter into saturation
            if (heard_flood && i == n / 2)
                repeat (260)
                    push_evt(MODE_HEARD, clock_ms, $urandom);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: register defaults
        src_idle_pct = 38;
        snk_idle_pct = 69;
        push_evt(MODE_TICK, 32'd0, 32'd0);               // tick before any reset
        push_evt(MODE_HEARD, 32'd0, 32'd0);
        push_evt(MODE_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_evt(MODE_RESET, 32'd1000, 32'hFFFF_FFFF);
        push_evt(MODE_TICK, 32'd1094, 32'd0);
        push_evt(MODE_TICK, 32'd1095, 32'd0);
        push_evt(MODE_TICK, 32'd1100, 32'h8000_0001);
        push_evt(MODE_HEARD, 32'd1200, 32'd0);
        push_evt(MODE_HEARD, 32'd1201, 32'd0);
        push_evt(MODE_HEARD, 32'd1202, 32'd0);
        push_evt(MODE_TICK, 32'd1400, 32'h5555_5555);    // suppressed by redundancy

        // half interval of zero, time wrapping through zero
        set_timer_regs(32'd1, 32'd1, 8'd1, 1'b1);
        push_evt(MODE_RESET, 32'hFFFF_FFFE, 32'd0);
        push_evt(MODE_TICK, 32'hFFFF_FFFE, 32'hAAAA_AAAA);
        push_evt(MODE_TICK, 32'hFFFF_FFFF, 32'h1);
        push_evt(MODE_TICK, 32'h0000_0000, 32'h2);

        // widest interval, doubling saturates, coordinator mode
        set_timer_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, 1'b0);
        push_evt(MODE_RESET, 32'h8000_0000, 32'h1234_5678);
        push_evt(MODE_TICK, 32'h8000_0001, 32'd0);
        push_evt(MODE_TICK, 32'h7FFF_FFFF, 32'hFFFF_FFFF);

        // cap below the minimum shrinks the interval
        set_timer_regs(32'd1000, 32'd10, 8'd255, 1'b1);
        push_evt(MODE_RESET, 32'd5, 32'd7);
        push_evt(MODE_HEARD, 32'd6, 32'd0);
        push_evt(MODE_TICK, 32'd512, 32'd0);
        push_evt(MODE_TICK, 32'd1005, 32'd3);
        push_evt(MODE_TICK, 32'd1020, 32'd9);

        // random, sender lighter idle than receiver
        set_timer_regs(32'd3, 32'd40, 8'd2, 1'b1);
        make_traffic(50, 32'd30, 1'b0);
        while (evt_pending.size() > 25)
            @(posedge clk);
        hold_inputs = 1'b1;
        wait_drained(1'b1);
        hold_inputs = 1'b0;
        set_timer_regs(32'd1, 32'd16, 8'd0, 1'b1);
        make_traffic(50, 32'd20, 1'b0);

        // random, idle rates swapped
        wait_drained(1'b0);
        src_idle_pct = 69;
        snk_idle_pct = 38;
        set_timer_regs(32'd2, 32'hFFFF_FFFF, 8'd255, 1'b1);
        make_traffic(50, 32'd12, 1'b1);
        set_timer_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 1'b0);
        make_traffic(50, 32'hFFFF_FFFF, 1'b0);

        // random, back to back
        wait_drained(1'b0);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_timer_regs(32'd9, 32'd4, 8'd3, 1'b0);
        make_traffic(50, 32'd15, 1'b0);
        set_timer_regs(32'd1, 32'd1, 8'd1, 1'b1);
        make_traffic(50, 32'd3, 1'b0);

        wait_drained(1'b0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (timer_results_due.size() != 0)
            flag_mismatch("results never delivered", 32'd0, timer_results_due.size());
        $display("Covered %0d events (%0d results, %0d beacons due) over 10 register settings",
                 events_taken, results_seen, beacons_due);
        $display("including heard saturation, wrapped time, capped and saturated doubling");
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
src/tbt_pkg.sv
src/tbt_serial_mod.sv
src/trickle_beacon_timer_unit.sv
bench/trickle_beacon_timer_unit_test.sv
